// ===== rtl/sktab_pkg.sv =====
// Shared types and constants for the sorted key/value table.
// Holds the transfer payload structs, command and status codes, and cell operations.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sktab_pkg;

    localparam logic [1:0] CMD_READ   = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 7;

    typedef struct packed {
        logic [1:0]        command;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0]  read_value;
        logic               found;
        logic [1:0]         status;
        logic [COUNT_W-1:0] entry_count;
    } rsp_t;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_UPDATE = 2'd1,
        OP_INSERT = 2'd2,
        OP_REMOVE = 2'd3
    } cell_op_t;

    typedef struct packed {
        logic     capture;
        cell_op_t op;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/sktab_cell.sv =====
// One slot of the sorted table: a key/value pair, its compare flags and the shift muxes.
// Depends on sktab_pkg for the cell control struct and operation codes.
`timescale 1ns / 1ps
`default_nettype none

module sktab_cell #(
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  sktab_pkg::cell_ctrl_t        ctrl,
    input  wire                          occupied,
    input  wire        [KEY_WIDTH-1:0]   cap_key,
    input  wire        [KEY_WIDTH-1:0]   new_key,
    input  wire        [VALUE_WIDTH-1:0] new_value,
    input  wire                          left_below,
    input  wire        [KEY_WIDTH-1:0]   left_key,
    input  wire        [VALUE_WIDTH-1:0] left_value,
    input  wire        [KEY_WIDTH-1:0]   right_key,
    input  wire        [VALUE_WIDTH-1:0] right_value,
    output logic       [KEY_WIDTH-1:0]   key,
    output logic       [VALUE_WIDTH-1:0] value,
    output logic                         below,
    output logic                         match
);

    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic                   below_reg;
    logic                   match_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            below_reg <= 1'b0;
            match_reg <= 1'b0;
        end else if (ctrl.capture) begin
            below_reg <= occupied && (key_reg < cap_key);
            match_reg <= occupied && (key_reg == cap_key);
        end
    end

    always_ff @(posedge aclk) begin
        case (ctrl.op)
            sktab_pkg::OP_UPDATE: begin
                if (match_reg) begin
                    value_reg <= new_value;
                end
            end
            sktab_pkg::OP_INSERT: begin
                if (!below_reg) begin
                    if (left_below) begin
                        key_reg   <= new_key;
                        value_reg <= new_value;
                    end else begin
                        key_reg   <= left_key;
                        value_reg <= left_value;
                    end
                end
            end
            sktab_pkg::OP_REMOVE: begin
                if (!below_reg) begin
                    key_reg   <= right_key;
                    value_reg <= right_value;
                end
            end
            default: begin
            end
        endcase
    end

    assign key   = key_reg;
    assign value = value_reg;
    assign below = below_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

// ===== rtl/sorted_key_value_table.sv =====
// A request is captured at acceptance, when every cell compares its key; in the update state the
// cells shift or update together and the result is registered, so no step depends on the fill
// level. A new request is taken only after the table has left the update state.
// A result left waiting holds the table in its update state until the transfer completes.
// Reset (aresetn, synchronous, active low) empties the table and clears both channels;
// stored keys and values are not cleared and are read only after being written.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_value_table #(
    parameter int CAPACITY    = 64,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  sktab_pkg::req_t       s_data,
    output logic                  m_valid,
    input  wire                   m_ready,
    output sktab_pkg::rsp_t       m_data
);

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_UPDATE = 2'b10
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [1:0]             cmd_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic                   m_valid_reg, m_valid_next;
    sktab_pkg::rsp_t        rsp_reg, rsp_next;

    sktab_pkg::cell_ctrl_t  ctrl;
    logic                   accept;
    logic                   advance;
    logic                   hit;
    logic                   full;
    logic [KEY_WIDTH-1:0]   cap_key;
    logic [VALUE_WIDTH-1:0] hit_value;

    logic [KEY_WIDTH-1:0]   cell_key   [CAPACITY];
    logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]    cell_below;
    logic [CAPACITY-1:0]    cell_match;
    logic [CAPACITY-1:0]    occupied;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign advance = (state_reg == ST_UPDATE) && (!m_valid_reg || m_ready);
    assign cap_key = KEY_WIDTH'(s_data.key);
    assign hit     = |cell_match;
    assign full    = (count_reg == CW'(CAPACITY));

    always_comb begin
        hit_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            occupied[i] = (count_reg > CW'(i));
            if (cell_match[i]) begin
                hit_value = hit_value | cell_value[i];
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic                   lb;
            logic [KEY_WIDTH-1:0]   lk;
            logic [VALUE_WIDTH-1:0] lv;
            logic [KEY_WIDTH-1:0]   rk;
            logic [VALUE_WIDTH-1:0] rv;

            if (g == 0) begin : g_first
                assign lb = 1'b1;
                assign lk = key_reg;
                assign lv = value_reg;
            end else begin : g_inner_left
                assign lb = cell_below[g-1];
                assign lk = cell_key[g-1];
                assign lv = cell_value[g-1];
            end

            if (g == CAPACITY - 1) begin : g_last
                assign rk = cell_key[g];
                assign rv = cell_value[g];
            end else begin : g_inner_right
                assign rk = cell_key[g+1];
                assign rv = cell_value[g+1];
            end

            sktab_cell #(
                .KEY_WIDTH   (KEY_WIDTH),
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl),
                .occupied    (occupied[g]),
                .cap_key     (cap_key),
                .new_key     (key_reg),
                .new_value   (value_reg),
                .left_below  (lb),
                .left_key    (lk),
                .left_value  (lv),
                .right_key   (rk),
                .right_value (rv),
                .key         (cell_key[g]),
                .value       (cell_value[g]),
                .below       (cell_below[g]),
                .match       (cell_match[g])
            );
        end
    endgenerate

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        rsp_next     = rsp_reg;
        ctrl.capture = accept;
        ctrl.op      = sktab_pkg::OP_NONE;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (advance) begin
                    state_next           = ST_IDLE;
                    m_valid_next         = 1'b1;
                    rsp_next.read_value  = '0;
                    rsp_next.found       = hit;
                    rsp_next.status      = sktab_pkg::STATUS_OK;
                    case (cmd_reg)
                        sktab_pkg::CMD_INSERT: begin
                            if (hit) begin
                                ctrl.op = sktab_pkg::OP_UPDATE;
                            end else if (full) begin
                                rsp_next.status = sktab_pkg::STATUS_FULL;
                            end else begin
                                ctrl.op    = sktab_pkg::OP_INSERT;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        sktab_pkg::CMD_REMOVE: begin
                            if (hit) begin
                                ctrl.op    = sktab_pkg::OP_REMOVE;
                                count_next = count_reg - CW'(1);
                            end else begin
                                rsp_next.status = sktab_pkg::STATUS_MISS;
                            end
                        end
                        default: begin
                            if (hit) begin
                                rsp_next.read_value = sktab_pkg::DATA_W'(hit_value);
                            end else begin
                                rsp_next.status = sktab_pkg::STATUS_MISS;
                            end
                        end
                    endcase
                    rsp_next.entry_count = sktab_pkg::COUNT_W'(count_next);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rsp_reg <= rsp_next;
        if (accept) begin
            cmd_reg   <= s_data.command;
            key_reg   <= KEY_WIDTH'(s_data.key);
            value_reg <= VALUE_WIDTH'(s_data.value);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = rsp_reg;

endmodule

`default_nettype wire

// ===== rtl/sktab_checker.sv =====
// Port-level checks for the sorted key/value table, attached by bind.
// Depends on sktab_pkg for payload types and status codes.
`timescale 1ns / 1ps
`default_nettype none

module sktab_checker #(
    parameter int CAPACITY = 64
) (
    input wire             aclk,
    input wire             aresetn,
    input wire             s_valid,
    input wire             s_ready,
    input wire             m_valid,
    input wire             m_ready,
    input sktab_pkg::rsp_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Result changed or dropped before its transfer.");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Request accepted while another is in progress.");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (CAPACITY < 128) |-> m_data.entry_count <= sktab_pkg::COUNT_W'(CAPACITY))
        else $error("Entry count exceeds capacity.");

    a_full_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == sktab_pkg::STATUS_FULL)
        |-> !m_data.found && (m_data.read_value == '0))
        else $error("Table-full result reports a hit or a value.");

    a_miss_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == sktab_pkg::STATUS_MISS)
        |-> !m_data.found && (m_data.read_value == '0))
        else $error("Missing-key result reports a hit or a value.");

endmodule

bind sorted_key_value_table sktab_checker #(
    .CAPACITY (CAPACITY)
) u_sktab_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

// ===== test/sorted_key_value_table_tb.sv =====
// Self-checking testbench for the sorted key/value table, driven through both valid/ready channels.
// An in-bench copy of the table predicts every response; it depends on sktab_pkg and the block RTL.
`timescale 1ns / 1ps

module sorted_key_value_table_tb;

    localparam int          TABLE_DEPTH  = 64;
    localparam int          POOL_SIZE    = 96;
    localparam int          LIMIT_CYCLES = 200000;
    localparam logic [1:0]  CMD_UNUSED   = 2'd3;

    logic            aclk    = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    sktab_pkg::req_t s_data  = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    sktab_pkg::rsp_t m_data;

    logic [sktab_pkg::DATA_W-1:0] table_keys[$];
    logic [sktab_pkg::DATA_W-1:0] table_values[$];
    sktab_pkg::rsp_t              pending_responses[$];
    logic [sktab_pkg::DATA_W-1:0] key_pool[POOL_SIZE];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  hold_request   = 0;
    int  hold_left      = 0;
    bit  idle_enabled   = 1'b1;

    sorted_key_value_table dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // The receiver stalls at random unless idling is disabled, or for a fixed stretch when a test asks for one.
    always @(negedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (!idle_enabled) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= 28);
        end
    end

    function automatic sktab_pkg::rsp_t table_lookup_update(sktab_pkg::req_t r);
        sktab_pkg::rsp_t rsp;
        int              pos;
        bit              hit;
        rsp = '0;
        pos = 0;
        while (pos < table_keys.size() && table_keys[pos] < r.key)
            pos++;
        hit = (pos < table_keys.size()) && (table_keys[pos] == r.key);
        case (r.command)
            sktab_pkg::CMD_INSERT: begin
                if (hit) begin
                    table_values[pos] = r.value;
                end else if (table_keys.size() >= TABLE_DEPTH) begin
                    rsp.status = sktab_pkg::STATUS_FULL;
                end else begin
                    table_keys.insert(pos, r.key);
                    table_values.insert(pos, r.value);
                end
            end
            sktab_pkg::CMD_REMOVE: begin
                if (hit) begin
                    table_keys.delete(pos);
                    table_values.delete(pos);
                end else begin
                    rsp.status = sktab_pkg::STATUS_MISS;
                end
            end
            default: begin
                // The unused command code behaves as a read.
                if (hit)
                    rsp.read_value = table_values[pos];
                else
                    rsp.status = sktab_pkg::STATUS_MISS;
            end
        endcase
        rsp.found       = hit;
        rsp.entry_count = sktab_pkg::COUNT_W'(table_keys.size());
        return rsp;
    endfunction

    always @(posedge aclk) begin
        sktab_pkg::rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_responses.size() == 0) begin
                $display("%0t: response with none expected, actual %h", $time, m_data);
                mismatch_count++;
            end else begin
                want = pending_responses.pop_front();
                if (m_data.read_value !== want.read_value) begin
                    $display("%0t: read_value expected %h actual %h",
                             $time, want.read_value, m_data.read_value);
                    mismatch_count++;
                end
                if (m_data.found !== want.found) begin
                    $display("%0t: found expected %b actual %b",
                             $time, want.found, m_data.found);
                    mismatch_count++;
                end
                if (m_data.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_data.status);
                    mismatch_count++;
                end
                if (m_data.entry_count !== want.entry_count) begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.entry_count, m_data.entry_count);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic sktab_pkg::req_t make_request(logic [1:0] command,
                                                     logic [sktab_pkg::DATA_W-1:0] key,
                                                     logic [sktab_pkg::DATA_W-1:0] value);
        sktab_pkg::req_t r;
        r.command = command;
        r.key     = key;
        r.value   = value;
        return r;
    endfunction

    // Called and returns at a falling edge; valid stays high after the transfer so that
    // a following request can go out back to back.
    task automatic send_request(sktab_pkg::req_t r);
        while (idle_enabled && $urandom_range(0, 99) < 28) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do
            @(posedge aclk);
        while (!s_ready);
        pending_responses.push_back(table_lookup_update(r));
        @(negedge aclk);
    endtask

    task automatic wait_for_responses();
        s_valid <= 1'b0;
        do
            @(negedge aclk);
        while (pending_responses.size() != 0);
    endtask

    task automatic test_directed();
        send_request(make_request(sktab_pkg::CMD_READ, 32'h0000_0000, $urandom()));
        send_request(make_request(sktab_pkg::CMD_REMOVE, 32'h0000_0005, $urandom()));
        send_request(make_request(sktab_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_request(make_request(sktab_pkg::CMD_INSERT, 32'h0000_0000, 32'h0000_0000));
        send_request(make_request(sktab_pkg::CMD_INSERT, 32'h8000_0000, 32'hA5A5_A5A5));
        send_request(make_request(sktab_pkg::CMD_INSERT, 32'h7FFF_FFFF, 32'h5A5A_5A5A));
        send_request(make_request(sktab_pkg::CMD_READ, 32'hFFFF_FFFF, $urandom()));
        send_request(make_request(sktab_pkg::CMD_READ, 32'h0000_0000, $urandom()));
        send_request(make_request(sktab_pkg::CMD_READ, 32'h0000_0001, $urandom()));
        send_request(make_request(sktab_pkg::CMD_INSERT, 32'h8000_0000, 32'h1234_5678));
        send_request(make_request(sktab_pkg::CMD_READ, 32'h8000_0000, $urandom()));
        send_request(make_request(CMD_UNUSED, 32'h7FFF_FFFF, $urandom()));
        send_request(make_request(CMD_UNUSED, 32'h0000_0003, $urandom()));
        send_request(make_request(sktab_pkg::CMD_REMOVE, 32'h7FFF_FFFF, $urandom()));
        send_request(make_request(sktab_pkg::CMD_REMOVE, 32'h7FFF_FFFF, $urandom()));
        send_request(make_request(sktab_pkg::CMD_READ, 32'h8000_0000, $urandom()));
        send_request(make_request(sktab_pkg::CMD_REMOVE, 32'h0000_0000, $urandom()));
        send_request(make_request(sktab_pkg::CMD_REMOVE, 32'hFFFF_FFFF, $urandom()));
        send_request(make_request(sktab_pkg::CMD_REMOVE, 32'h8000_0000, $urandom()));
        send_request(make_request(sktab_pkg::CMD_READ, 32'h8000_0000, $urandom()));
        wait_for_responses();
    endtask

    // Runs without idling on either side: fills the table, overflows it, then empties it.
    task automatic test_full_table();
        logic [sktab_pkg::DATA_W-1:0] remaining[$];
        int                           idx;
        idle_enabled = 1'b0;
        while (table_keys.size() < TABLE_DEPTH)
            send_request(make_request(sktab_pkg::CMD_INSERT, $urandom(), $urandom()));
        repeat (4)
            send_request(make_request(sktab_pkg::CMD_INSERT, $urandom(), $urandom()));
        send_request(make_request(sktab_pkg::CMD_INSERT, table_keys[0], $urandom()));
        send_request(make_request(sktab_pkg::CMD_INSERT, table_keys[TABLE_DEPTH-1],
                                  $urandom()));
        send_request(make_request(sktab_pkg::CMD_READ, table_keys[TABLE_DEPTH-1], $urandom()));
        send_request(make_request(sktab_pkg::CMD_REMOVE, table_keys[TABLE_DEPTH/2],
                                  $urandom()));
        send_request(make_request(sktab_pkg::CMD_INSERT, $urandom(), $urandom()));
        send_request(make_request(sktab_pkg::CMD_INSERT, $urandom(), $urandom()));
        remaining = table_keys;
        while (remaining.size() != 0) begin
            idx = $urandom_range(0, remaining.size() - 1);
            send_request(make_request(sktab_pkg::CMD_REMOVE, remaining[idx], $urandom()));
            remaining.delete(idx);
        end
        wait_for_responses();
        idle_enabled = 1'b1;
    endtask

    task automatic test_backpressure();
        hold_request = 150;
        repeat (12)
            send_request(make_request(sktab_pkg::CMD_INSERT,
                                      key_pool[$urandom_range(0, POOL_SIZE - 1)],
                                      $urandom()));
        wait_for_responses();
    endtask

    task automatic test_random_traffic(int count, int insert_pct, int remove_pct);
        logic [1:0]                   command;
        logic [sktab_pkg::DATA_W-1:0] key;
        int                           pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < insert_pct)
                command = sktab_pkg::CMD_INSERT;
            else if (pick < insert_pct + remove_pct)
                command = sktab_pkg::CMD_REMOVE;
            else if (pick < 95)
                command = sktab_pkg::CMD_READ;
            else
                command = CMD_UNUSED;
            if ($urandom_range(0, 99) < 80)
                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                key = $urandom();
            send_request(make_request(command, key, $urandom()));
        end
        wait_for_responses();
    endtask

    initial begin
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom();

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_full_table();
        test_backpressure();
        test_random_traffic(150, 45, 20);
        test_random_traffic(150, 65, 10);
        test_random_traffic(100, 25, 50);
        test_random_traffic(120, 60, 15);

        repeat (10) @(posedge aclk);
        if (pending_responses.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
